// File: rtl/h264_nal_unit_splitter_assert.svh
// Assertion macros for the NAL unit splitter; the using module supplies clk and arst_n.
`ifndef H264_NAL_UNIT_SPLITTER_ASSERT_SVH
`define H264_NAL_UNIT_SPLITTER_ASSERT_SVH
`ifndef SYNTH
`define NUS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("nal splitter check failed");
`define NUS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nal splitter check failed");
`else
`define NUS_ASSERT_NOW(label, ante, cons)
`define NUS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/nus_pkg.sv
package nus_pkg;

	localparam int PACKET_LEN_BITS = 24;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);

	localparam logic [1:0] PH_SEARCH = 2'd0;
	localparam logic [1:0] PH_UNIT = 2'd1;
	localparam logic [1:0] PH_DROP = 2'd2;
	localparam logic [1:0] PH_IDLE = 2'd3;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_END = 2'd1;
	localparam logic [1:0] KIND_OVERSIZE = 2'd2;

	localparam logic [2:0] MAX_PREFIX = 3'd4;
	localparam logic [7:0] TYPE_MASK = 8'h1F;
	localparam logic [1:0] ZERO_RUN_MAX = 2'd2;

	typedef struct packed {
		logic [7:0]                 in_byte;
		logic                       packet_start;
		logic [PACKET_LEN_BITS-1:0] packet_len;
		logic                       packet_end;
	} in_item_t;

	typedef struct packed {
		logic [1:0] item_kind;
		logic [7:0] out_byte;
		logic       first_of_unit;
		logic [4:0] unit_type;
		logic [1:0] ref_level;
		logic       last_of_run;
	} out_item_t;

	typedef struct packed {
		logic [1:0] zeros;
		logic       has_byte;
		logic [7:0] data_byte;
		logic       has_end;
		logic       oversize;
		logic       first;
	} run_t;

endpackage

// File: rtl/h264_nal_unit_splitter.sv
// H.264 NAL unit splitter: takes packet bytes and emits NAL unit bytes and markers.
// Input channel: a queue write port; a byte transaction completes when push is high
// and full is low. packet_start marks the first byte and carries packet_len;
// packet_end marks the last byte.
// Result channel: a queue read port; the oldest result sits on result while empty
// is low and leaves when pop is high. Each result is a unit byte (header fields on
// the first byte of a unit), an end-of-unit marker or an oversize-length marker.
// Configuration: cfg_valid/cfg_data write prefix_size (0 start codes, 1..4 length
// prefix bytes, larger values act as 4); cfg_ready is always high and full is held
// high while cfg_valid is high. Write only while no results are pending.
// Path: each result passes through the run queue and then the output register, and
// waits longer when earlier results are still waiting.
// Throughput: one byte per cycle while full is low; a four-entry run queue feeds the
// back expander, which delivers one result per cycle while pop is high, so a byte
// that causes more than one result holds the result port until all have left.
// Reset clears the parser, the run queue and the output valid flag; prefix_size is 0.
// When the receiver stalls, the run queue fills and full rises to hold the sender.
module h264_nal_unit_splitter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  nus_pkg::in_item_t  data,
	output logic               empty,
	input  logic               pop,
	output nus_pkg::out_item_t result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_data
);

	logic          q_wr;
	logic          q_rd;
	logic          q_full;
	logic          q_empty;
	nus_pkg::run_t q_run;
	nus_pkg::run_t q_head;

	assign cfg_ready = 1'b1;
	assign full = q_full || cfg_valid;

	nus_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid),
		.cfg_data (cfg_data),
		.push     (push),
		.data     (data),
		.q_full   (q_full),
		.q_wr     (q_wr),
		.q_run    (q_run)
	);

	nus_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wr_run (q_run),
		.rd     (q_rd),
		.head   (q_head),
		.full   (q_full),
		.empty  (q_empty)
	);

	nus_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (q_head),
		.q_empty (q_empty),
		.q_rd    (q_rd),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

endmodule

// File: rtl/nus_front.sv
module nus_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_data,
	input  logic              push,
	input  nus_pkg::in_item_t data,
	input  logic              q_full,
	output logic              q_wr,
	output nus_pkg::run_t     q_run
);

	localparam int PLB = nus_pkg::PACKET_LEN_BITS;

	logic [2:0]     prefix_q;
	logic [1:0]     phase_q;
	logic [1:0]     zero_run_q;
	logic           unit_open_q;
	logic [2:0]     prefix_count_q;
	logic [31:0]    length_accum_q;
	logic [31:0]    unit_left_q;
	logic [PLB-1:0] packet_left_q;

	logic           accept;
	logic [2:0]     sz;
	logic [1:0]     ph;
	logic [1:0]     zr;
	logic           uo;
	logic [2:0]     pc;
	logic [31:0]    acc;
	logic [31:0]    ubl;
	logic [PLB-1:0] pbl;
	logic [PLB-1:0] left;
	logic [31:0]    acc_sh;
	logic [1:0]     nz;
	logic           hb;
	logic           he;
	logic           ov;
	logic           first;

	assign accept = push && !q_full && !cfg_we;

	always_comb begin
		sz = (prefix_q > nus_pkg::MAX_PREFIX) ? nus_pkg::MAX_PREFIX : prefix_q;
		ph = phase_q;
		zr = zero_run_q;
		uo = unit_open_q;
		pc = prefix_count_q;
		acc = length_accum_q;
		ubl = unit_left_q;
		pbl = packet_left_q;
		left = '0;
		nz = 2'd0;
		hb = 1'b0;
		he = 1'b0;
		ov = 1'b0;
		if (data.packet_start) begin
			ph = nus_pkg::PH_SEARCH;
			zr = 2'd0;
			uo = 1'b0;
			pc = 3'd0;
			acc = 32'd0;
			ubl = 32'd0;
			pbl = data.packet_len;
		end
		if (pbl != '0) begin
			pbl = pbl - 1'b1;
		end
		first = !uo;
		acc_sh = {acc[23:0], data.in_byte};
		if (ph != nus_pkg::PH_IDLE) begin
			if (sz == 3'd0) begin
				if (ph == nus_pkg::PH_SEARCH) begin
					if (data.in_byte == 8'd0) begin
						if (zr < nus_pkg::ZERO_RUN_MAX) zr = zr + 1'b1;
					end else begin
						if (data.in_byte == 8'd1 && zr >= nus_pkg::ZERO_RUN_MAX) begin
							ph = nus_pkg::PH_UNIT;
							uo = 1'b0;
						end
						zr = 2'd0;
					end
				end else begin
					if (data.in_byte == 8'd0) begin
						if (zr >= nus_pkg::ZERO_RUN_MAX) begin
							nz = 2'd1;
							uo = 1'b1;
						end else begin
							zr = zr + 1'b1;
						end
					end else if (data.in_byte == 8'd1 && zr >= nus_pkg::ZERO_RUN_MAX) begin
						he = uo;
						uo = 1'b0;
						zr = 2'd0;
					end else begin
						nz = zr;
						hb = 1'b1;
						uo = 1'b1;
						zr = 2'd0;
					end
				end
				if (data.packet_end) begin
					if (ph == nus_pkg::PH_UNIT) begin
						nz = nz + zr;
						if (zr != 2'd0) uo = 1'b1;
						if (uo) he = 1'b1;
					end
					ph = nus_pkg::PH_IDLE;
					zr = 2'd0;
					uo = 1'b0;
					pc = 3'd0;
					acc = 32'd0;
					ubl = 32'd0;
				end
			end else begin
				if (ph == nus_pkg::PH_SEARCH) begin
					acc = acc_sh;
					pc = pc + 1'b1;
					if (pc >= sz) begin
						left = data.packet_end ? '0 : pbl;
						pc = 3'd0;
						if (acc_sh > 32'(left)) begin
							ov = 1'b1;
							ph = nus_pkg::PH_DROP;
						end else if (acc_sh != 32'd0) begin
							ph = nus_pkg::PH_UNIT;
							ubl = acc_sh;
							uo = 1'b0;
						end
						acc = 32'd0;
					end
				end else if (ph == nus_pkg::PH_UNIT) begin
					hb = 1'b1;
					uo = 1'b1;
					if (ubl != 32'd0) ubl = ubl - 1'b1;
					if (ubl == 32'd0) begin
						he = 1'b1;
						uo = 1'b0;
						ph = nus_pkg::PH_SEARCH;
					end
				end
				if (data.packet_end) begin
					if (ph == nus_pkg::PH_UNIT && uo) he = 1'b1;
					ph = nus_pkg::PH_IDLE;
					zr = 2'd0;
					uo = 1'b0;
					pc = 3'd0;
					acc = 32'd0;
					ubl = 32'd0;
				end
			end
		end
	end

	assign q_run.zeros = nz;
	assign q_run.has_byte = hb;
	assign q_run.data_byte = data.in_byte;
	assign q_run.has_end = he;
	assign q_run.oversize = ov;
	assign q_run.first = first;
	assign q_wr = accept && (nz != 2'd0 || hb || he || ov);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= 3'd0;
			phase_q <= nus_pkg::PH_SEARCH;
			zero_run_q <= 2'd0;
			unit_open_q <= 1'b0;
			prefix_count_q <= 3'd0;
			length_accum_q <= 32'd0;
			unit_left_q <= 32'd0;
			packet_left_q <= '0;
		end else if (cfg_we) begin
			prefix_q <= cfg_data;
			phase_q <= nus_pkg::PH_SEARCH;
			zero_run_q <= 2'd0;
			unit_open_q <= 1'b0;
			prefix_count_q <= 3'd0;
			length_accum_q <= 32'd0;
			unit_left_q <= 32'd0;
		end else if (accept) begin
			phase_q <= ph;
			zero_run_q <= zr;
			unit_open_q <= uo;
			prefix_count_q <= pc;
			length_accum_q <= acc;
			unit_left_q <= ubl;
			packet_left_q <= pbl;
		end
	end

endmodule

// File: rtl/nus_queue.sv
`include "h264_nal_unit_splitter_assert.svh"

module nus_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  nus_pkg::run_t wr_run,
	input  logic          rd,
	output nus_pkg::run_t head,
	output logic          full,
	output logic          empty
);

	localparam int PB = nus_pkg::QPTR_BITS;

	nus_pkg::run_t mem_q [nus_pkg::QUEUE_DEPTH];
	logic [PB-1:0] wr_ptr_q;
	logic [PB-1:0] rd_ptr_q;
	logic [PB:0]   count_q;

	assign full = count_q == (PB+1)'(nus_pkg::QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_run;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (wr && !rd) count_q <= count_q + 1'b1;
			else if (rd && !wr) count_q <= count_q - 1'b1;
		end
	end

	`NUS_ASSERT_NOW(a_no_overflow, wr, !full)
	`NUS_ASSERT_NOW(a_no_underflow, rd, !empty)
	`NUS_ASSERT_NEXT(a_count_up, wr && !rd, count_q == $past(count_q) + 1'b1)

endmodule

// File: rtl/nus_back.sv
`include "h264_nal_unit_splitter_assert.svh"

module nus_back (
	input  logic               clk,
	input  logic               arst_n,
	input  nus_pkg::run_t      head,
	input  logic               q_empty,
	output logic               q_rd,
	input  logic               pop,
	output logic               empty,
	output nus_pkg::out_item_t result
);

	nus_pkg::out_item_t res_q;
	nus_pkg::out_item_t cur;
	logic               valid_q;
	logic [1:0]         step_q;
	logic [2:0]         run_len;
	logic               last;
	logic               load;
	logic [7:0]         hdr;

	assign run_len = {1'b0, head.zeros} + {2'b0, head.has_byte} + {2'b0, head.has_end}
		+ {2'b0, head.oversize};
	assign last = ({1'b0, step_q} + 3'd1) == run_len;
	assign load = (!valid_q || pop) && !q_empty;
	assign q_rd = load && last;

	always_comb begin
		cur = '0;
		if (head.oversize) begin
			cur.item_kind = nus_pkg::KIND_OVERSIZE;
		end else if (step_q < head.zeros) begin
			cur.item_kind = nus_pkg::KIND_DATA;
		end else if (head.has_byte && step_q == head.zeros) begin
			cur.item_kind = nus_pkg::KIND_DATA;
			cur.out_byte = head.data_byte;
		end else begin
			cur.item_kind = nus_pkg::KIND_END;
		end
		cur.first_of_unit = head.first && step_q == 2'd0
			&& cur.item_kind == nus_pkg::KIND_DATA;
		hdr = cur.first_of_unit ? cur.out_byte : 8'd0;
		cur.unit_type = 5'(hdr & nus_pkg::TYPE_MASK);
		cur.ref_level = hdr[6:5];
		cur.last_of_run = last;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			step_q <= 2'd0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				step_q <= last ? 2'd0 : step_q + 1'b1;
			end else if (pop) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign empty = !valid_q;
	assign result = res_q;

	`NUS_ASSERT_NOW(a_step_in_run, !q_empty, 3'(step_q) < run_len)
	`NUS_ASSERT_NOW(a_step_needs_run, step_q != 2'd0, !q_empty)
	`NUS_ASSERT_NEXT(a_load_shows, load, valid_q && result == $past(cur))

endmodule

// File: tb/h264_nal_unit_splitter_tb.sv
module h264_nal_unit_splitter_tb;

	localparam int CYCLE_LIMIT = 100000;
	localparam int SETTLE_CYCLES = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	nus_pkg::in_item_t data = '0;
	logic empty;
	logic pop = 1'b0;
	nus_pkg::out_item_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_data = 3'd0;

	nus_pkg::in_item_t pending_bytes[$];
	nus_pkg::out_item_t expected_results[$];
	nus_pkg::out_item_t step_results[$];
	logic [7:0] packet_buf[$];
	int bytes_queued = 0;
	int errors = 0;
	int cycles = 0;

	logic [2:0] prefix_size_reg;
	logic [1:0] parse_phase;
	logic [1:0] zero_count;
	logic unit_open;
	logic [2:0] prefix_got;
	logic [31:0] length_acc;
	logic [31:0] unit_left;
	logic [nus_pkg::PACKET_LEN_BITS-1:0] packet_left;

	int burst_left = 0;
	int gap_left = 0;
	logic [7:0] stall_pat = 8'hFF;
	int pat_left = 0;

	h264_nal_unit_splitter u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.data(data),
		.empty(empty),
		.pop(pop),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	task automatic report(input string msg);
		errors++;
		if (errors <= 100) $display("h264_nal_unit_splitter_tb: %s", msg);
	endtask

	task automatic clear_parse();
		parse_phase = nus_pkg::PH_SEARCH;
		zero_count = 2'd0;
		unit_open = 1'b0;
		prefix_got = 3'd0;
		length_acc = 32'd0;
		unit_left = 32'd0;
	endtask

	task automatic emit(input logic [1:0] kind, input logic [7:0] b);
		nus_pkg::out_item_t r;
		logic first;
		first = (kind == nus_pkg::KIND_DATA) && !unit_open;
		if (first) unit_open = 1'b1;
		r = '0;
		r.item_kind = kind;
		if (kind == nus_pkg::KIND_DATA) r.out_byte = b;
		r.first_of_unit = first;
		if (first) begin
			r.unit_type = 5'(b & nus_pkg::TYPE_MASK);
			r.ref_level = b[6:5];
		end
		step_results.push_back(r);
	endtask

	task automatic emit_zeros(input logic [1:0] count);
		for (int i = 0; i < count && i < 3; i++) emit(nus_pkg::KIND_DATA, 8'h00);
	endtask

	task automatic split_byte(input nus_pkg::in_item_t it);
		logic [2:0] sz;
		logic [31:0] left;
		logic [7:0] b;
		nus_pkg::out_item_t r;
		b = it.in_byte;
		step_results.delete();
		sz = (prefix_size_reg > nus_pkg::MAX_PREFIX) ? nus_pkg::MAX_PREFIX : prefix_size_reg;
		if (it.packet_start) begin
			clear_parse();
			packet_left = it.packet_len;
		end
		if (packet_left != 0) packet_left--;

		if (parse_phase != nus_pkg::PH_IDLE) begin
			if (sz == 3'd0) begin
				if (parse_phase == nus_pkg::PH_SEARCH) begin
					if (b == 8'h00) begin
						if (zero_count < nus_pkg::ZERO_RUN_MAX) zero_count++;
					end else begin
						if (b == 8'h01 && zero_count >= nus_pkg::ZERO_RUN_MAX) begin
							parse_phase = nus_pkg::PH_UNIT;
							unit_open = 1'b0;
						end
						zero_count = 2'd0;
					end
				end else begin
					if (b == 8'h00) begin
						if (zero_count >= nus_pkg::ZERO_RUN_MAX) emit(nus_pkg::KIND_DATA, 8'h00);
						else zero_count++;
					end else if (b == 8'h01 && zero_count >= nus_pkg::ZERO_RUN_MAX) begin
						if (unit_open) emit(nus_pkg::KIND_END, 8'h00);
						unit_open = 1'b0;
						zero_count = 2'd0;
					end else begin
						emit_zeros(zero_count);
						zero_count = 2'd0;
						emit(nus_pkg::KIND_DATA, b);
					end
				end
				if (it.packet_end) begin
					if (parse_phase == nus_pkg::PH_UNIT) begin
						emit_zeros(zero_count);
						if (unit_open) emit(nus_pkg::KIND_END, 8'h00);
					end
					clear_parse();
					parse_phase = nus_pkg::PH_IDLE;
				end
			end else begin
				if (parse_phase == nus_pkg::PH_SEARCH) begin
					length_acc = {length_acc[23:0], b};
					prefix_got++;
					if (prefix_got >= sz) begin
						left = it.packet_end ? 32'd0 : 32'(packet_left);
						prefix_got = 3'd0;
						if (length_acc > left) begin
							emit(nus_pkg::KIND_OVERSIZE, 8'h00);
							parse_phase = nus_pkg::PH_DROP;
						end else if (length_acc != 0) begin
							parse_phase = nus_pkg::PH_UNIT;
							unit_left = length_acc;
							unit_open = 1'b0;
						end
						length_acc = 32'd0;
					end
				end else if (parse_phase == nus_pkg::PH_UNIT) begin
					emit(nus_pkg::KIND_DATA, b);
					if (unit_left != 0) unit_left--;
					if (unit_left == 0) begin
						emit(nus_pkg::KIND_END, 8'h00);
						unit_open = 1'b0;
						parse_phase = nus_pkg::PH_SEARCH;
					end
				end
				if (it.packet_end) begin
					if (parse_phase == nus_pkg::PH_UNIT && unit_open)
						emit(nus_pkg::KIND_END, 8'h00);
					clear_parse();
					parse_phase = nus_pkg::PH_IDLE;
				end
			end
		end

		foreach (step_results[i]) begin
			r = step_results[i];
			r.last_of_run = (i == step_results.size() - 1);
			expected_results.push_back(r);
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			prefix_size_reg = 3'd0;
			packet_left = '0;
			clear_parse();
		end else begin
			if (cfg_valid && cfg_ready) begin
				prefix_size_reg = cfg_data;
				clear_parse();
			end
			if (push && !full) split_byte(data);
		end
	end

	// hold the item until the transaction completes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			data <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!push || !full) begin
			if (gap_left != 0) begin
				push <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_bytes.size() != 0) begin
				push <= 1'b1;
				data <= pending_bytes.pop_front();
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 12);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				push <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		nus_pkg::out_item_t want;
		if (!arst_n) begin
			pop <= 1'b0;
			stall_pat <= 8'hFF;
			pat_left <= 0;
		end else begin
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					report($sformatf("unexpected result kind %0d byte %02h",
						result.item_kind, result.out_byte));
				end else begin
					want = expected_results.pop_front();
					if (result !== want)
						report($sformatf({"result mismatch: got %0d/%02h/%0b/%0d/%0d/%0b, ",
							"expected %0d/%02h/%0b/%0d/%0d/%0b"},
							result.item_kind, result.out_byte, result.first_of_unit,
							result.unit_type, result.ref_level, result.last_of_run,
							want.item_kind, want.out_byte, want.first_of_unit,
							want.unit_type, want.ref_level, want.last_of_run));
				end
			end
			pop <= stall_pat[0];
			if (pat_left == 0) begin
				stall_pat <= ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
				pat_left <= $urandom_range(16, 96);
			end else begin
				stall_pat <= {stall_pat[0], stall_pat[7:1]};
				pat_left <= pat_left - 1;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("h264_nal_unit_splitter_tb: FAIL");
			$finish;
		end
	end

	task automatic add_byte(input logic [7:0] b, input logic ps, input logic [23:0] len,
			input logic pe);
		nus_pkg::in_item_t it;
		it.in_byte = b;
		it.packet_start = ps;
		it.packet_len = ps ? len : 24'($urandom);
		it.packet_end = pe;
		pending_bytes.push_back(it);
		bytes_queued++;
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_bytes.size() != 0 || push || expected_results.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_prefix_size(input logic [2:0] value);
		wait_drained();
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [7:0] body_byte();
		case ($urandom_range(0, 5))
			0, 1: return 8'h00;
			2: return 8'h03;
			3: return 8'h01;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic send_packet();
		logic [23:0] len;
		logic with_end;
		len = 24'(packet_buf.size());
		with_end = ($urandom_range(0, 9) != 0);
		case ($urandom_range(0, 7))
			0: len = 24'($urandom);
			1: len = len + 24'($urandom_range(0, 3));
			2: if (len > 2) len = len - 24'($urandom_range(1, 2));
			default: len = len;
		endcase
		foreach (packet_buf[i])
			add_byte(packet_buf[i], i == 0, len, with_end && (i == packet_buf.size() - 1));
	endtask

	task automatic build_annexb();
		packet_buf.delete();
		repeat ($urandom_range(0, 2)) packet_buf.push_back(8'($urandom));
		repeat ($urandom_range(1, 3)) begin
			if ($urandom_range(0, 3) == 0) packet_buf.push_back(8'h00);
			packet_buf.push_back(8'h00);
			packet_buf.push_back(8'h00);
			packet_buf.push_back(8'h01);
			packet_buf.push_back(8'($urandom) & (($urandom_range(0, 7) == 0) ? 8'hFF : 8'h7F));
			repeat ($urandom_range(0, 4)) packet_buf.push_back(body_byte());
		end
		if ($urandom_range(0, 3) == 0) packet_buf.push_back(8'h00);
	endtask

	task automatic build_length(input int sz);
		logic [31:0] len;
		int body;
		packet_buf.delete();
		repeat ($urandom_range(1, 3)) begin
			len = $urandom_range(0, 5);
			body = len;
			case ($urandom_range(0, 9))
				0: len = $urandom;
				1: body = $urandom_range(0, body);
				default: body = body;
			endcase
			for (int i = sz - 1; i >= 0; i--) packet_buf.push_back(8'(len >> (8 * i)));
			repeat (body) packet_buf.push_back(8'($urandom));
		end
	endtask

	task automatic add_noise();
		repeat ($urandom_range(1, 6))
			add_byte(8'($urandom), $urandom_range(0, 3) == 0,
				($urandom_range(0, 1) == 0) ? 24'($urandom_range(0, 8)) : 24'($urandom),
				$urandom_range(0, 3) == 0);
	endtask

	initial begin
		logic [2:0] cfg_order[9];
		int target;
		int sz;
		cfg_order = '{3'd4, 3'd7, 3'd0, 3'd2, 3'd5, 3'd3, 3'd1, 3'd6, 3'd0};

		// start-code mode straight out of reset, no packet_start yet
		add_byte(8'hFF, 1'b0, 24'd0, 1'b0);
		add_byte(8'h00, 1'b0, 24'd0, 1'b0);
		add_byte(8'h00, 1'b0, 24'd0, 1'b0);
		add_byte(8'h01, 1'b0, 24'd0, 1'b0);
		add_byte(8'hE5, 1'b0, 24'd0, 1'b0);
		add_byte(8'h00, 1'b0, 24'd0, 1'b0);
		add_byte(8'h00, 1'b0, 24'd0, 1'b0);
		add_byte(8'h00, 1'b0, 24'd0, 1'b0);
		add_byte(8'h01, 1'b0, 24'd0, 1'b0);
		add_byte(8'h61, 1'b0, 24'd0, 1'b0);
		add_byte(8'h00, 1'b0, 24'd0, 1'b0);
		add_byte(8'h00, 1'b0, 24'd0, 1'b0);
		add_byte(8'h7F, 1'b0, 24'd0, 1'b1);
		add_byte(8'h33, 1'b0, 24'd0, 1'b0);
		add_byte(8'h00, 1'b1, 24'hFFFFFF, 1'b0);
		add_byte(8'h00, 1'b0, 24'd0, 1'b0);
		add_byte(8'h01, 1'b0, 24'd0, 1'b0);
		add_byte(8'h9F, 1'b0, 24'd0, 1'b0);
		add_byte(8'h00, 1'b1, 24'd0, 1'b0);

		// one-byte prefix, continuing the open packet
		write_prefix_size(3'd1);
		add_byte(8'h02, 1'b0, 24'd0, 1'b0);
		add_byte(8'h44, 1'b0, 24'd0, 1'b0);
		add_byte(8'h00, 1'b1, 24'd3, 1'b0);
		add_byte(8'h01, 1'b0, 24'd0, 1'b0);
		add_byte(8'hFF, 1'b0, 24'd0, 1'b1);
		add_byte(8'h03, 1'b1, 24'd100, 1'b0);
		add_byte(8'h41, 1'b0, 24'd0, 1'b0);
		add_byte(8'h42, 1'b0, 24'd0, 1'b1);

		foreach (cfg_order[p]) begin
			write_prefix_size(cfg_order[p]);
			sz = (cfg_order[p] > nus_pkg::MAX_PREFIX) ? int'(nus_pkg::MAX_PREFIX)
				: int'(cfg_order[p]);
			target = bytes_queued + 10;
			while (bytes_queued < target) begin
				if ($urandom_range(0, 9) < 8) begin
					if (sz == 0) build_annexb();
					else build_length(sz);
					send_packet();
				end else begin
					add_noise();
				end
			end
		end

		wait_drained();
		if (!empty) report("result left over after the last transaction");
		if (errors == 0) begin
			$display("h264_nal_unit_splitter_tb: PASS");
		end else begin
			$display("h264_nal_unit_splitter_tb: FAIL");
		end
		$finish;
	end

endmodule
